FILE: design/lft_pkg.sv
// Shared types and constants for the login failure throttle table.
// Used by lft_ctrl, lft_datapath and login_failure_throttle_table.
`default_nettype none

package lft_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_WINDOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_ENABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXEMPT_ADDR    = 3'd4;

  localparam logic [7:0]  RST_LOCK_THRESHOLD = 8'd3;
  localparam logic [15:0] RST_LOCK_WINDOW    = 16'd900;
  localparam logic [15:0] RST_SHORT_WINDOW   = 16'd15;
  localparam logic        RST_SHORT_ENABLE   = 1'b1;
  localparam logic [31:0] RST_EXEMPT_ADDR    = 32'hFF00_0001;

  localparam logic [7:0] FAIL_MAX = 8'hFF;

  localparam logic ACT_CHECK  = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_OK    = 2'd0,
    VERDICT_SHORT = 2'd1,
    VERDICT_LOCK  = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  failures;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_ONE,
    PTR_NEXT,
    PTR_TOP
  } ptr_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_MOVE,
    WR_APPEND,
    WR_REPORT
  } wr_op_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    logic    capture;
    logic    emit;
    ptr_op_t ptr_op;
    wr_op_t  wr_op;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic full;
    logic rd_vld;
    logic match;
    logic rd_last;
  } status_t;

endpackage

`default_nettype wire

FILE: design/lft_ctrl.sv
// Sequencer for the throttle table: scan, compaction, append and report steps.
// Depends on lft_pkg for the command and status structs.
`default_nettype none

module lft_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             action,
  input  wire lft_pkg::status_t st,
  output lft_pkg::cmd_t         cmd,
  output logic                  busy
);
  import lft_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_MOVE   = 6'b000100,
    S_APPEND = 6'b001000,
    S_RPT_RD = 6'b010000,
    S_RPT_WR = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.ptr_op  = PTR_HOLD;
    cmd.wr_op   = WR_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (action == ACT_CHECK) begin
            if (st.cnt_zero) begin
              state_next = S_APPEND;
            end else begin
              cmd.ptr_op = PTR_ZERO;
              state_next = S_SCAN;
            end
          end else if (!st.cnt_zero) begin
            cmd.ptr_op = PTR_TOP;
            state_next = S_RPT_RD;
          end
        end
      end
      S_SCAN: begin
        if (st.rd_vld && st.match) begin
          cmd.capture = 1'b1;
          if (st.rd_last) begin
            state_next = S_APPEND;
          end else begin
            cmd.ptr_op = PTR_NEXT;
            state_next = S_MOVE;
          end
        end else if (st.rd_vld && st.rd_last) begin
          // miss: a full table drops its oldest entry first
          if (st.full) begin
            cmd.ptr_op = PTR_ONE;
            state_next = S_MOVE;
          end else begin
            state_next = S_APPEND;
          end
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      S_MOVE: begin
        cmd.rd_en = 1'b1;
        if (st.rd_vld) begin
          cmd.wr_op = WR_MOVE;
          if (st.rd_last) begin
            state_next = S_APPEND;
          end
        end
      end
      S_APPEND: begin
        cmd.wr_op  = WR_APPEND;
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      S_RPT_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_RPT_WR;
      end
      S_RPT_WR: begin
        cmd.wr_op  = WR_REPORT;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

FILE: design/lft_datapath.sv
// Datapath of the throttle table: entry memory, fill count, pointers,
// configuration registers and verdict logic. Depends on lft_pkg.
`default_nettype none

module lft_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire lft_pkg::cmd_t                    cmd,
  output lft_pkg::status_t                      st,
  input  wire logic [31:0]                      client_address,
  input  wire logic [31:0]                      now_seconds,
  input  wire logic                             login_failed,
  input  wire logic                             cfg_write,
  input  wire logic [lft_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lft_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                  verdict_valid,
  output logic [1:0]                            verdict
);
  import lft_pkg::*;

  // configuration
  logic [7:0]  lock_threshold;
  logic [15:0] lock_window;
  logic [15:0] short_window;
  logic        short_enable;
  logic [31:0] exempt_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_threshold <= RST_LOCK_THRESHOLD;
      lock_window    <= RST_LOCK_WINDOW;
      short_window   <= RST_SHORT_WINDOW;
      short_enable   <= RST_SHORT_ENABLE;
      exempt_addr    <= RST_EXEMPT_ADDR;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LOCK_THRESHOLD: lock_threshold <= cfg_data[7:0];
        CFG_LOCK_WINDOW:    lock_window    <= cfg_data[15:0];
        CFG_SHORT_WINDOW:   short_window   <= cfg_data[15:0];
        CFG_SHORT_ENABLE:   short_enable   <= cfg_data[0];
        CFG_EXEMPT_ADDR:    exempt_addr    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // table memory; slot 0 is least recently used
  entry_t mem [TABLE_DEPTH];

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] ptr;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_slot;
  entry_t           rd_data;
  logic             rd_go;

  logic [31:0] req_addr;
  logic [31:0] req_now;
  logic        req_failed;
  logic        use_hit;
  logic [7:0]  hit_fail;
  logic [31:0] hit_stamp;
  verdict_t    verdict_reg;

  logic             keep_cnt;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_data;
  logic [7:0]       rpt_fail;

  logic [31:0] elapsed;
  verdict_t    judged;

  assign cnt_m1   = cnt - 1'b1;
  assign rd_go    = cmd.rd_en && (ptr < cnt);
  assign keep_cnt = use_hit || st.full;

  assign st.cnt_zero = (cnt == '0);
  assign st.full     = (cnt == CNT_W'(TABLE_DEPTH));
  assign st.rd_vld   = rd_vld;
  assign st.match    = (rd_data.address == req_addr);
  assign st.rd_last  = (rd_slot == cnt_m1[IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      ptr    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_go;
      if (cmd.wr_op == WR_APPEND && !keep_cnt) begin
        cnt <= cnt + 1'b1;
      end
      case (cmd.ptr_op)
        PTR_ZERO: ptr <= '0;
        PTR_ONE:  ptr <= CNT_W'(1);
        PTR_NEXT: ptr <= CNT_W'(rd_slot) + 1'b1;
        PTR_TOP:  ptr <= cnt_m1;
        default: begin
          if (rd_go) begin
            ptr <= ptr + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      rd_data <= mem[ptr[IDX_W-1:0]];
      rd_slot <= ptr[IDX_W-1:0];
    end
  end

  assign rpt_fail = !req_failed ? 8'd0 :
                    (rd_data.failures == FAIL_MAX) ? FAIL_MAX : rd_data.failures + 8'd1;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = rd_slot;
    wr_data = rd_data;
    case (cmd.wr_op)
      WR_MOVE: begin
        wr_en  = 1'b1;
        wr_idx = rd_slot - 1'b1;
      end
      WR_APPEND: begin
        wr_en            = 1'b1;
        wr_idx           = keep_cnt ? cnt_m1[IDX_W-1:0] : cnt[IDX_W-1:0];
        wr_data.address  = req_addr;
        wr_data.failures = use_hit ? hit_fail : 8'd0;
        wr_data.stamp    = use_hit ? hit_stamp : req_now;
      end
      WR_REPORT: begin
        wr_en            = 1'b1;
        wr_data.failures = rpt_fail;
        wr_data.stamp    = req_now;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // request and hit capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_addr   <= client_address;
      req_now    <= now_seconds;
      req_failed <= login_failed;
    end
    if (cmd.capture) begin
      hit_fail  <= rd_data.failures;
      hit_stamp <= rd_data.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_hit <= 1'b0;
    end else if (cmd.load) begin
      use_hit <= 1'b0;
    end else if (cmd.capture) begin
      use_hit <= 1'b1;
    end
  end

  // elapsed time wraps modulo 2^32
  assign elapsed = req_now - hit_stamp;

  always_comb begin
    judged = VERDICT_OK;
    if (!use_hit || req_addr == exempt_addr) begin
      judged = VERDICT_OK;
    end else if (hit_fail >= lock_threshold) begin
      judged = (elapsed <= {16'd0, lock_window}) ? VERDICT_LOCK : VERDICT_OK;
    end else if (hit_fail != 8'd0 && short_enable) begin
      judged = (elapsed <= {16'd0, short_window}) ? VERDICT_SHORT : VERDICT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      verdict_reg <= judged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else begin
      verdict_valid <= cmd.emit;
    end
  end

  assign verdict = verdict_reg;

endmodule

`default_nettype wire

FILE: design/login_failure_throttle_table.sv
// Login failure throttle table: an LRU-ordered table of client addresses
// with failure counts and time stamps. A check item is taken when start is
// high and busy is low; its verdict appears for one cycle with verdict_valid,
// and cannot be held off by the receiver. A report item gives no verdict.
// Timing is set by the single-read-port entry memory, visited one slot per
// cycle. A check scans the valid entries and appends the client as the
// newest entry: a hit first moves the entries after it down one slot, a
// miss into a full table first compacts all entries to drop the oldest,
// and a check on an empty table appends without a scan. A report reads and
// rewrites the newest entry, or does nothing on an empty table. The verdict
// is valid in the first cycle with busy low again. Config writes take effect
// at once. Depends on lft_pkg, lft_ctrl and lft_datapath.
`default_nettype none

module login_failure_throttle_table (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            action,
  input  wire logic [31:0]                     client_address,
  input  wire logic [31:0]                     now_seconds,
  input  wire logic                            login_failed,
  input  wire logic                            cfg_write,
  input  wire logic [lft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lft_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                 verdict_valid,
  output logic [1:0]                           verdict
);
  import lft_pkg::*;

  cmd_t    cmd;
  status_t st;

  lft_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .st     (st),
    .cmd    (cmd),
    .busy   (busy)
  );

  lft_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .client_address (client_address),
    .now_seconds    (now_seconds),
    .login_failed   (login_failed),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .verdict_valid  (verdict_valid),
    .verdict        (verdict)
  );

`ifndef ASSERT_OFF
  // a check item taken while idle always sets busy
  a_check_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_CHECK) |=> busy)
    else $error("check item did not start work");

  // a verdict only follows work on a check
  a_verdict_after_work: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> $past(busy))
    else $error("verdict without preceding work");

  // one verdict per item, never two in a row
  a_single_verdict: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |=> !verdict_valid)
    else $error("verdict strobe held for two cycles");

  // a report never produces a verdict; a check right after it may
  a_report_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_REPORT) |=>
      !verdict_valid ##1 !verdict_valid)
    else $error("report item produced a verdict");
`endif

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for login_failure_throttle_table: directed and random
// check/report items, verdicts predicted by a local LRU table model.
// Depends on lft_pkg and the login_failure_throttle_table RTL.
module testbench;
  import lft_pkg::*;

  localparam int LIMIT_CYCLES  = 800_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 64;
  localparam int PHASES        = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  action = ACT_CHECK;
  logic [31:0]           client_address = '0;
  logic [31:0]           now_seconds = '0;
  logic                  login_failed = 1'b0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_LOCK_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  busy;
  logic                  verdict_valid;
  logic [1:0]            verdict;

  // Tracks the LRU table and registers, queues the verdict each check should give.
  class throttle_book;
    entry_t      lru[$];        // index 0 is least recently used
    verdict_t    expected[$];
    logic [7:0]  threshold;
    logic [15:0] lock_window;
    logic [15:0] short_window;
    logic        short_enable;
    logic [31:0] exempt;
    int          errors;

    function new();
      threshold    = RST_LOCK_THRESHOLD;
      lock_window  = RST_LOCK_WINDOW;
      short_window = RST_SHORT_WINDOW;
      short_enable = RST_SHORT_ENABLE;
      exempt       = RST_EXEMPT_ADDR;
      errors       = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LOCK_THRESHOLD: threshold = data[7:0];
        CFG_LOCK_WINDOW:    lock_window = data[15:0];
        CFG_SHORT_WINDOW:   short_window = data[15:0];
        CFG_SHORT_ENABLE:   short_enable = data[0];
        CFG_EXEMPT_ADDR:    exempt = data[31:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function verdict_t judge(entry_t e, logic [31:0] now);
      logic [31:0] elapsed;
      elapsed = now - e.stamp;  // wraps mod 2^32
      if (e.address == exempt) return VERDICT_OK;
      if (e.failures >= threshold) begin
        if (elapsed <= {16'd0, lock_window}) return VERDICT_LOCK;
        return VERDICT_OK;
      end
      if (e.failures != 8'd0 && short_enable) begin
        if (elapsed <= {16'd0, short_window}) return VERDICT_SHORT;
        return VERDICT_OK;
      end
      return VERDICT_OK;
    endfunction

    function void note_item(logic act, logic [31:0] addr, logic [31:0] now, logic failed);
      entry_t e;
      int     top;
      if (act == ACT_REPORT) begin
        if (lru.size() == 0) return;
        top = lru.size() - 1;
        e = lru[top];
        if (!failed) e.failures = '0;
        else if (e.failures != FAIL_MAX) e.failures = e.failures + 8'd1;
        e.stamp = now;
        lru[top] = e;
        return;
      end
      for (int i = 0; i < lru.size(); i++) begin
        if (lru[i].address == addr) begin
          e = lru[i];
          lru.delete(i);
          lru.push_back(e);
          expected.push_back(judge(e, now));
          return;
        end
      end
      if (lru.size() == TABLE_DEPTH) lru.delete(0);
      e.address  = addr;
      e.failures = '0;
      e.stamp    = now;
      lru.push_back(e);
      expected.push_back(VERDICT_OK);
    endfunction

    task log_mismatch(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_verdict(logic [1:0] got);
      verdict_t want;
      if (expected.size() == 0) begin
        log_mismatch($sformatf("verdict %0d with no check pending", got));
        return;
      end
      want = expected.pop_front();
      if (got !== want)
        log_mismatch($sformatf("verdict %0d, expected %0d (%s)", got, want, want.name()));
    endtask
  endclass

  throttle_book book = new();
  int unsigned  item_count = 0;
  bit           burst = 1'b0;
  int           win_hint = 0;
  logic [31:0]  clock_s = '0;

  login_failure_throttle_table DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && verdict_valid === 1'b1) book.check_verdict(verdict);
  end

  // start stays high across back-to-back items; this task lowers it only when a gap is drawn
  task automatic send_item(logic act, logic [31:0] addr, logic [31:0] now, logic failed);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    action         <= act;
    client_address <= addr;
    now_seconds    <= now;
    login_failed   <= failed;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (act == ACT_CHECK || book.lru.size() != 0) item_count++;
    book.note_item(act, addr, now, failed);
  endtask

  task automatic check_addr(logic [31:0] addr, logic [31:0] now);
    send_item(ACT_CHECK, addr, now, 1'($urandom_range(0, 1)));
  endtask

  task automatic report_outcome(logic failed, logic [31:0] now);
    send_item(ACT_REPORT, $urandom(), now, failed);
  endtask

  // reports give no verdict, so allow the block to finish one after the queue drains
  task automatic settle();
    start <= 1'b0;
    while (book.pending() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    book.set_register(idx, data);
  endtask

  // upper data bits carry junk; a write to an unused index must change nothing
  task automatic load_config(logic [7:0] thr, logic [15:0] lwin, logic [15:0] swin,
                             logic en, logic [31:0] ex);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(CFG_LOCK_THRESHOLD, {junk[31:8], thr});
    write_reg(CFG_LOCK_WINDOW, {junk[31:16], lwin});
    write_reg(CFG_SHORT_WINDOW, {junk[15:0], swin});
    write_reg(CFG_SHORT_ENABLE, {junk[31:1], en});
    write_reg(CFG_EXEMPT_ADDR, ex);
    write_reg(CFG_IDX_W'($urandom_range(CFG_EXEMPT_ADDR + 1, 2**CFG_IDX_W - 1)), $urandom());
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] step_time(logic [31:0] t);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return t + $urandom_range(0, 3);
    if (r < 88) return t + $urandom_range(0, 2 * win_hint + 2);
    if (r < 96) return t + $urandom();
    return t - $urandom_range(1, 1000);  // clock going backwards
  endfunction

  task automatic run_phase();
    logic [31:0] pool[$];
    logic [31:0] addr;
    int unsigned stop_at;
    int          reps;
    int          kind;
    stop_at  = item_count + PHASE_ITEMS;
    win_hint = (book.lock_window > book.short_window) ? book.lock_window : book.short_window;
    if (win_hint > 2000) win_hint = 2000;
    // small pools hit often; large ones overflow the table and evict
    repeat ($urandom_range(0, 1) ? $urandom_range(3, 10) : $urandom_range(70, 100))
      pool.push_back($urandom());
    pool[0] = book.exempt;
    pool[1] = 32'h0000_0000;
    pool[2] = 32'hFFFF_FFFF;
    clock_s = $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 300);
    while (item_count < stop_at) begin
      burst = ($urandom_range(0, 4) == 0);
      kind  = $urandom_range(0, 9);
      if (kind < 7) begin
        // login attempts on one client: check, then mostly a failed outcome
        addr = pool[$urandom_range(0, pool.size() - 1)];
        reps = $urandom_range(1, 6);
        repeat (reps) begin
          clock_s = step_time(clock_s);
          check_addr(addr, clock_s);
          if ($urandom_range(0, 9) != 0) begin
            clock_s = step_time(clock_s);
            report_outcome($urandom_range(0, 3) != 0, clock_s);
          end
        end
      end else if (kind < 9) begin
        clock_s = step_time(clock_s);
        if ($urandom_range(0, 1)) report_outcome(1'($urandom_range(0, 1)), clock_s);
        else check_addr($urandom(), clock_s);
      end else begin
        send_item(1'($urandom_range(0, 1)), $urandom(), $urandom(), 1'($urandom_range(0, 1)));
      end
    end
    burst = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: threshold 3, windows 900 and 15, exempt address FF00_0001
    report_outcome(1'b1, 32'hFFFF_FFFF);    // empty table: ignored
    check_addr(RST_EXEMPT_ADDR, 32'd0);     // exempt miss is still added
    repeat (4) report_outcome(1'b1, 32'd0);
    check_addr(RST_EXEMPT_ADDR, 32'd1);     // over threshold but exempt
    check_addr(32'h0000_0000, 32'hFFFF_FFF0);
    report_outcome(1'b1, 32'hFFFF_FFF0);
    check_addr(32'h0000_0000, 32'hFFFF_FFFF);  // one failure, at the short window edge
    check_addr(32'h0000_0000, 32'h0000_0000);  // wrapped, one past the window
    repeat (2) report_outcome(1'b1, 32'd100);
    check_addr(32'h0000_0000, 32'd1000);       // lockout at the window edge
    check_addr(32'h0000_0000, 32'd1001);
    check_addr(32'h0000_0000, 32'd99);         // time went backwards
    check_addr(32'hFFFF_FFFF, 32'd50);
    report_outcome(1'b1, 32'd60);
    report_outcome(1'b0, 32'd61);              // success clears the count
    check_addr(32'hFFFF_FFFF, 32'd62);
    check_addr(32'h0000_0000, 32'd105);

    // failure count saturates at its maximum
    burst = 1'b1;
    check_addr(32'h5A5A_A5A5, 32'd5000);
    repeat (260) report_outcome(1'b1, 32'd5000);
    burst = 1'b0;
    check_addr(32'h5A5A_A5A5, 32'd5001);
    report_outcome(1'b1, 32'd5002);
    check_addr(32'h5A5A_A5A5, 32'd5003);

    run_phase();
    for (int p = 1; p < PHASES; p++) begin
      settle();
      case (p)
        1: load_config(8'd1, 16'd0, 16'd0, 1'b0, 32'h0000_0000);
        2: load_config(FAIL_MAX, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        3: load_config(8'd0, 16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)), 1'b1,
                       $urandom());
        7: load_config(8'($urandom()), 16'($urandom()), 16'($urandom()),
                       1'($urandom_range(0, 1)), $urandom());
        default: load_config(8'($urandom_range(1, 5)), 16'($urandom_range(0, 60)),
                             16'($urandom_range(0, 30)), 1'($urandom_range(0, 1)),
                             $urandom());
      endcase
      run_phase();
    end

    settle();
    if (book.errors == 0 && book.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/lft_pkg.sv
design/lft_ctrl.sv
design/lft_datapath.sv
design/login_failure_throttle_table.sv
verif/testbench.sv
